// ===== src/prbt_pkg.sv =====
// ----------------------------------------------------------------------------
// prbt_pkg
// Shared constants for the prefix bucket routing table: default widths,
// operation codes and result status codes.
// ----------------------------------------------------------------------------
package prbt_pkg;

   localparam int DEF_KEY_BITS   = 64;
   localparam int DEF_VALUE_BITS = 32;

   localparam int OP_BITS     = 3;
   localparam int STATUS_BITS = 3;
   localparam int IDX_BITS    = 7;

   // operation codes
   localparam logic [OP_BITS-1:0] OP_INSERT     = 3'd0;
   localparam logic [OP_BITS-1:0] OP_REMOVE_KV  = 3'd1;
   localparam logic [OP_BITS-1:0] OP_REMOVE_KEY = 3'd2;
   localparam logic [OP_BITS-1:0] OP_LOOKUP     = 3'd3;
   localparam logic [OP_BITS-1:0] OP_HEAD       = 3'd4;

   // result status codes
   localparam logic [STATUS_BITS-1:0] STATUS_OK        = 3'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_REJECT    = 3'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_SELF      = 3'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY     = 3'd3;
   localparam logic [STATUS_BITS-1:0] STATUS_BAD_INDEX = 3'd4;

endpackage

// ===== src/prbt_ram.sv =====
// ----------------------------------------------------------------------------
// prbt_ram
// Generic single-port-write, single-port-read synchronous RAM with a
// registered read that updates only when a read is enabled.
// ----------------------------------------------------------------------------
module prbt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/prbt_prefix.sv =====
// ----------------------------------------------------------------------------
// prbt_prefix
// Common-prefix length of two keys, counted from the most significant bit,
// plus an equality flag.
// ----------------------------------------------------------------------------
module prbt_prefix #(
   parameter int KEY_BITS = prbt_pkg::DEF_KEY_BITS,
   localparam int CW = $clog2(KEY_BITS + 1)
) (
   input  logic [KEY_BITS-1:0] key_a,
   input  logic [KEY_BITS-1:0] key_b,
   output logic [CW-1:0]       prefix_len,
   output logic                equal
);

   logic [KEY_BITS-1:0] diff;

   assign diff  = key_a ^ key_b;
   assign equal = (diff == '0);

   // highest differing bit wins
   always_comb begin
      prefix_len = CW'(KEY_BITS);
      for (int i = 0; i < KEY_BITS; i++) begin
         if (diff[i]) begin
            prefix_len = CW'(KEY_BITS - 1 - i);
         end
      end
   end

endmodule

// ===== src/prefix_bucket_routing_table.sv =====
// ----------------------------------------------------------------------------
// prefix_bucket_routing_table
// Routing table of a distributed hash node: one stack-shaped bucket per
// common-prefix length with the node id.
// ----------------------------------------------------------------------------
// Usage:
//   csr_*  : write channel for node_id; always ready, write only while idle.
//   req_*  : one word per operation (insert, remove key+value, remove key,
//            lookup, read bucket head), valid/ready.
//   rsp_*  : exactly one result word per request, valid/ready, held in an
//            output register until taken.
// Steps: the accept cycle reads the bucket fill count memory; the top-read
//   step (S_TOP) reads the top entry from the entry memory at an address
//   built from that count; the resolve step (S_EXEC) resolves the operation,
//   writes back the memories it updates and accepts the next word, so a new
//   request overlaps the resolve step of the last one. A fill count written
//   back in the same cycle the next word reads it is forwarded.
// Reset: synchronous, clears node_id, the control state and one valid bit
//   per bucket, so every bucket reads as empty at once (no clearing pass).
// Stall: while a result waits on rsp_ready, one more request is accepted
//   and read; it holds in its resolve step until the output register frees.
// ----------------------------------------------------------------------------
module prefix_bucket_routing_table #(
   parameter int KEY_BITS   = prbt_pkg::DEF_KEY_BITS,
   parameter int VALUE_BITS = prbt_pkg::DEF_VALUE_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   // configuration
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [KEY_BITS-1:0]             csr_node_id,
   // request
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [prbt_pkg::OP_BITS-1:0]    req_op,
   input  logic [KEY_BITS-1:0]             req_key,
   input  logic [VALUE_BITS-1:0]           req_value,
   input  logic [prbt_pkg::IDX_BITS-1:0]   req_bucket_index,
   // response
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [prbt_pkg::STATUS_BITS-1:0] rsp_status,
   output logic                            rsp_next_hop,
   output logic [KEY_BITS-1:0]             rsp_entry_key,
   output logic [VALUE_BITS-1:0]           rsp_entry_value
);

   import prbt_pkg::*;

   localparam int DEPTH = (KEY_BITS * (KEY_BITS + 1)) / 2;
   localparam int AW    = $clog2(DEPTH);
   localparam int PW    = AW + 1;
   localparam int BW    = $clog2(KEY_BITS);
   localparam int FW    = $clog2(KEY_BITS + 1);
   localparam int EW    = KEY_BITS + VALUE_BITS;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_TOP  = 2'd1;
   localparam logic [1:0] S_EXEC = 2'd2;

   // registers
   logic [1:0]             state_ff, state_in;
   logic [KEY_BITS-1:0]    node_ff, node_in;
   logic [OP_BITS-1:0]     op_ff, op_in;
   logic [KEY_BITS-1:0]    key_ff, key_in;
   logic [VALUE_BITS-1:0]  value_ff, value_in;
   logic                   self_ff, self_in;
   logic                   bad_idx_ff, bad_idx_in;
   logic [BW-1:0]          sel_ff, sel_in;
   logic [KEY_BITS-1:0]    fvalid_ff, fvalid_in;
   logic                   fvalid_rd_ff, fvalid_rd_in;
   logic                   fwd_ff, fwd_in;
   logic [FW-1:0]          fwd_fill_ff, fwd_fill_in;
   logic [FW-1:0]          fill_ff, fill_in;
   logic                   full_ff, full_in;
   logic [AW-1:0]          ins_slot_ff, ins_slot_in;
   logic [KEY_BITS-1:0]    bid_ff, bid_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic                   rsp_hop_ff, rsp_hop_in;
   logic [KEY_BITS-1:0]    rsp_key_ff, rsp_key_in;
   logic [VALUE_BITS-1:0]  rsp_value_ff, rsp_value_in;

   // combinational
   logic                   accept;
   logic                   done;
   logic [FW-1:0]          pfx_len;
   logic                   pfx_equal;
   logic [BW-1:0]          acc_sel;
   logic [FW-1:0]          fill_q;
   logic [EW-1:0]          store_q;
   logic [FW-1:0]          fill_cur;
   logic [PW-1:0]          sel_w;
   logic [PW-1:0]          base_w;
   logic [AW-1:0]          base;
   logic [AW-1:0]          top_addr;
   logic [BW-1:0]          flip_pos;
   logic [KEY_BITS-1:0]    top_key;
   logic [VALUE_BITS-1:0]  top_value;
   logic [KEY_BITS-1:0]    dist_top;
   logic [KEY_BITS-1:0]    dist_new;
   logic                   top_closer;
   logic                   fill_zero;
   logic [STATUS_BITS-1:0] res_status;
   logic                   res_hop;
   logic [KEY_BITS-1:0]    res_key;
   logic [VALUE_BITS-1:0]  res_value;
   logic                   fill_upd;
   logic                   store_upd;
   logic [FW-1:0]          fill_wdata;
   logic                   fill_we;
   logic                   store_we;

   // -------------------------------------------------------------------------
   // Handshake
   // -------------------------------------------------------------------------
   assign csr_ready = 1'b1;
   assign done      = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign req_ready = (state_ff == S_IDLE) || done;
   assign accept    = req_valid && req_ready;

   // -------------------------------------------------------------------------
   // Bucket selection at accept: prefix length with node id, or the index
   // -------------------------------------------------------------------------
   prbt_prefix #(
      .KEY_BITS (KEY_BITS)
   ) u_prefix (
      .key_a      (req_key),
      .key_b      (node_ff),
      .prefix_len (pfx_len),
      .equal      (pfx_equal)
   );

   assign acc_sel = (req_op == OP_HEAD) ? req_bucket_index[BW-1:0] : pfx_len[BW-1:0];

   // -------------------------------------------------------------------------
   // Memories: fill count per bucket, and key/value entries of all buckets
   // -------------------------------------------------------------------------
   prbt_ram #(
      .WIDTH (FW),
      .DEPTH (KEY_BITS)
   ) u_fill_ram (
      .clock   (clock),
      .wr_en   (fill_we),
      .wr_addr (sel_ff),
      .wr_data (fill_wdata),
      .rd_en   (accept),
      .rd_addr (acc_sel),
      .rd_data (fill_q)
   );

   prbt_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (ins_slot_ff),
      .wr_data ({key_ff, value_ff}),
      .rd_en   (state_ff == S_TOP),
      .rd_addr (top_addr),
      .rd_data (store_q)
   );

   // -------------------------------------------------------------------------
   // Top-read step: current fill (forwarded or never-written bucket reads
   // zero), bucket base address, top slot, capacity and bucket id
   // -------------------------------------------------------------------------
   always_comb begin
      if (fwd_ff) begin
         fill_cur = fwd_fill_ff;
      end else if (fvalid_rd_ff) begin
         fill_cur = fill_q;
      end else begin
         fill_cur = '0;
      end
      // base(i) = i*K - i*(i-1)/2
      sel_w    = PW'(sel_ff);
      base_w   = sel_w * PW'(KEY_BITS) - ((sel_w * (sel_w - PW'(1))) >> 1);
      base     = base_w[AW-1:0];
      top_addr = (fill_cur == '0) ? base : base + AW'(fill_cur) - AW'(1);
      flip_pos = BW'(KEY_BITS - 1) - sel_ff;
   end

   // -------------------------------------------------------------------------
   // Resolve step
   // -------------------------------------------------------------------------
   assign top_key   = store_q[EW-1:VALUE_BITS];
   assign top_value = store_q[VALUE_BITS-1:0];
   assign dist_top  = top_key ^ bid_ff;
   assign dist_new  = key_ff ^ bid_ff;
   // longer common prefix with bucket id <=> leading one sits lower
   assign top_closer = (dist_top < dist_new) && (dist_top < (dist_top ^ dist_new));
   assign fill_zero  = (fill_ff == '0);

   always_comb begin
      res_status = STATUS_REJECT;
      res_hop    = 1'b0;
      res_key    = '0;
      res_value  = '0;
      fill_upd   = 1'b0;
      store_upd  = 1'b0;
      fill_wdata = fill_ff;
      unique case (op_ff)
         OP_INSERT: begin
            if (!self_ff && !(!fill_zero && top_closer) && !full_ff) begin
               res_status = STATUS_OK;
               fill_upd   = 1'b1;
               store_upd  = 1'b1;
               fill_wdata = fill_ff + FW'(1);
            end
         end
         OP_REMOVE_KV, OP_REMOVE_KEY: begin
            if (!self_ff && !fill_zero && (top_key == key_ff) &&
                ((op_ff == OP_REMOVE_KEY) || (top_value == value_ff))) begin
               res_status = STATUS_OK;
               fill_upd   = 1'b1;
               fill_wdata = fill_ff - FW'(1);
            end
         end
         OP_LOOKUP: begin
            if (self_ff) begin
               res_status = STATUS_SELF;
            end else if (fill_zero) begin
               res_status = STATUS_EMPTY;
            end else begin
               res_status = STATUS_OK;
               res_hop    = (top_key != key_ff);
               res_key    = top_key;
               res_value  = top_value;
            end
         end
         OP_HEAD: begin
            if (bad_idx_ff) begin
               res_status = STATUS_BAD_INDEX;
            end else if (fill_zero) begin
               res_status = STATUS_EMPTY;
            end else begin
               res_status = STATUS_OK;
               res_key    = top_key;
               res_value  = top_value;
            end
         end
         default: begin
            res_status = STATUS_REJECT;
         end
      endcase
   end

   assign fill_we  = done && fill_upd;
   assign store_we = done && store_upd;

   // -------------------------------------------------------------------------
   // Next-state logic
   // -------------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      node_in      = node_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      self_in      = self_ff;
      bad_idx_in   = bad_idx_ff;
      sel_in       = sel_ff;
      fvalid_in    = fvalid_ff;
      fvalid_rd_in = fvalid_rd_ff;
      fwd_in       = fwd_ff;
      fwd_fill_in  = fwd_fill_ff;
      fill_in      = fill_ff;
      full_in      = full_ff;
      ins_slot_in  = ins_slot_ff;
      bid_in       = bid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_hop_in   = rsp_hop_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_value_in = rsp_value_ff;

      if (csr_valid) begin
         node_in = csr_node_id;
      end

      // drop the result once taken; a new one may replace it below
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // mark a bucket as written once its fill count goes to memory
      if (fill_we) begin
         fvalid_in[sel_ff] = 1'b1;
      end

      // capture the word and forward a fill count written this same edge
      if (accept) begin
         op_in        = req_op;
         key_in       = req_key;
         value_in     = req_value;
         self_in      = pfx_equal;
         bad_idx_in   = (req_bucket_index >= IDX_BITS'(KEY_BITS));
         sel_in       = acc_sel;
         fvalid_rd_in = fvalid_ff[acc_sel];
         fwd_in       = fill_we && (acc_sel == sel_ff);
         fwd_fill_in  = fill_wdata;
      end

      // the forwarded count is consumed here; drop it
      if (state_ff == S_TOP) begin
         fwd_in      = 1'b0;
         fill_in     = fill_cur;
         full_in     = (fill_cur >= (FW'(KEY_BITS) - FW'(sel_ff)));
         ins_slot_in = base + AW'(fill_cur);
         bid_in      = node_ff ^ (KEY_BITS'(1) << flip_pos);
      end

      if (done) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status;
         rsp_hop_in    = res_hop;
         rsp_key_in    = res_key;
         rsp_value_in  = res_value;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_TOP;
            end
         end
         S_TOP: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (accept) begin
               state_in = S_TOP;
            end else if (done) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // -------------------------------------------------------------------------
   // Registers
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         node_ff      <= '0;
         fvalid_ff    <= '0;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         node_ff      <= node_in;
         fvalid_ff    <= fvalid_in;
         fwd_ff       <= fwd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      self_ff       <= self_in;
      bad_idx_ff    <= bad_idx_in;
      sel_ff        <= sel_in;
      fvalid_rd_ff  <= fvalid_rd_in;
      fwd_fill_ff   <= fwd_fill_in;
      fill_ff       <= fill_in;
      full_ff       <= full_in;
      ins_slot_ff   <= ins_slot_in;
      bid_ff        <= bid_in;
      rsp_status_ff <= rsp_status_in;
      rsp_hop_ff    <= rsp_hop_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_next_hop    = rsp_hop_ff;
   assign rsp_entry_key   = rsp_key_ff;
   assign rsp_entry_value = rsp_value_ff;

   // -------------------------------------------------------------------------
   // Assertions
   // -------------------------------------------------------------------------
   a_no_accept_in_top: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TOP) |-> !req_ready)
      else $error("request accepted during top-entry read");

   a_accept_to_top: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_TOP))
      else $error("accepted word did not advance to top-entry read");

   a_entry_write_in_range: assert property (@(posedge clock) disable iff (reset)
      store_we |-> (int'(ins_slot_ff) < DEPTH))
      else $error("entry write beyond memory depth");

   a_fill_within_capacity: assert property (@(posedge clock) disable iff (reset)
      fill_we |-> (int'(fill_wdata) <= KEY_BITS - int'(sel_ff)))
      else $error("bucket fill exceeds its capacity");

   a_forward_only_on_read: assert property (@(posedge clock) disable iff (reset)
      fwd_ff |-> (state_ff == S_TOP))
      else $error("fill forward pending outside top-entry read");

endmodule
